[rtl/adc_median_of_samples_defines.svh]
// Assertion macros used by the median filter datapath.
`ifndef ADC_MEDIAN_OF_SAMPLES_DEFINES_SVH
`define ADC_MEDIAN_OF_SAMPLES_DEFINES_SVH

// Whenever the condition holds, the consequence must hold on the next clock edge.
`define AMOS_ASSERT_NEXT(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("assertion failed");

// The expression must hold on every clock edge outside reset.
`define AMOS_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`endif

[rtl/amos_pkg.sv]
// Shared constants and control types for the median filter.
`default_nettype none
package amos_pkg;
  localparam int MAX_SAMPLES_DEF = 15;
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int FIELD_W         = 12;
  localparam int TDATA_W         = 16;
  localparam int CFG_W           = 4;
  localparam int APB_ADDR_W      = 3;
  localparam int APB_DATA_W      = 32;

  localparam logic [TDATA_W-1:0] FIELD_MASK = TDATA_W'((1 << FIELD_W) - 1);
  // Register index of sample_count, taken from paddr above the byte offset.
  localparam logic [APB_ADDR_W-3:0] REG_SAMPLE_COUNT = '0;

  typedef struct packed {
    logic take;   // accept one attempt word; insert it if it is a good sample and the store has room
    logic pick;   // load the median into the output register, start a new run
  } dp_cmd_t;

  typedef struct packed {
    logic run_end;    // the attempt on offer completes the run
    logic out_stall;  // output register full and not being taken
  } dp_stat_t;
endpackage
`default_nettype wire

[rtl/amos_ctrl.sv]
// Controller sequencing attempt intake and median output.
`default_nettype none
module amos_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire amos_pkg::dp_stat_t stat,
  output amos_pkg::dp_cmd_t      cmd
);
  localparam logic ST_TAKE = 1'b0;
  localparam logic ST_PICK = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    cmd.take   = 1'b0;
    cmd.pick   = 1'b0;
    s_tready   = 1'b0;
    case (state)
      ST_TAKE: begin
        s_tready = 1'b1;
        cmd.take = s_tvalid;
        if (s_tvalid && stat.run_end) begin
          state_next = ST_PICK;
        end
      end
      ST_PICK: begin
        if (!stat.out_stall) begin
          cmd.pick   = 1'b1;
          state_next = ST_TAKE;
        end
      end
      default: state_next = ST_TAKE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_TAKE;
    end else begin
      state <= state_next;
    end
  end
endmodule
`default_nettype wire

[rtl/amos_dp.sv]
// Datapath: sorted sample store, run counters and output register.
`default_nettype none
`include "adc_median_of_samples_defines.svh"
module amos_dp #(
  parameter int MAX_SAMPLES = amos_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = amos_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire amos_pkg::dp_cmd_t             cmd,
  output amos_pkg::dp_stat_t                 stat,
  input  wire logic [amos_pkg::CFG_W-1:0]    sample_count,
  input  wire logic [amos_pkg::FIELD_W-1:0]  sample_value,
  input  wire logic                          sample_ok,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [amos_pkg::TDATA_W-1:0]       m_tdata,
  output logic                               m_tuser
);
  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int EW    = (CNT_W > amos_pkg::CFG_W) ? CNT_W : amos_pkg::CFG_W;

  logic [SAMPLE_BITS-1:0] store      [MAX_SAMPLES];
  logic [SAMPLE_BITS-1:0] store_next [MAX_SAMPLES];
  logic [SAMPLE_BITS-1:0] prev       [MAX_SAMPLES];
  logic [MAX_SAMPLES-1:0] gt;
  logic [MAX_SAMPLES-1:0] gt_prev;
  logic [CNT_W-1:0]       attempts;
  logic [CNT_W-1:0]       kept;
  logic                   full;
  logic [amos_pkg::TDATA_W-1:0] vin_wide;
  logic [SAMPLE_BITS-1:0] vin;
  logic [EW-1:0]          eff;
  logic [EW:0]            attempts_p1;
  logic [CNT_W-1:0]       mid;
  logic [SAMPLE_BITS-1:0] median;
  logic                   out_valid;
  logic [SAMPLE_BITS-1:0] out_value;
  logic                   out_empty;

  assign vin_wide = amos_pkg::TDATA_W'(sample_value);
  assign vin      = vin_wide[SAMPLE_BITS-1:0];
  assign full     = (kept == CNT_W'(MAX_SAMPLES));

  // Effective run length: zero counts as one, clamped to the store depth.
  always_comb begin
    eff = EW'(sample_count);
    if (eff == '0) begin
      eff = EW'(1);
    end
    if (eff > EW'(MAX_SAMPLES)) begin
      eff = EW'(MAX_SAMPLES);
    end
  end

  assign attempts_p1    = (EW + 1)'(attempts) + (EW + 1)'(1);
  assign stat.run_end   = (attempts_p1 >= (EW + 1)'(eff));
  assign stat.out_stall = out_valid && !m_tready;

  // Insertion into the sorted row while it is not full: every entry above the new value moves up one place.
  always_comb begin
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      gt[i] = (CNT_W'(i) < kept) && (store[i] > vin);
    end
    prev[0]    = vin;
    gt_prev[0] = 1'b0;
    for (int i = 1; i < MAX_SAMPLES; i++) begin
      prev[i]    = store[i-1];
      gt_prev[i] = gt[i-1];
    end
    for (int i = 0; i < MAX_SAMPLES; i++) begin
      store_next[i] = store[i];
      if (!full && (gt[i] || (CNT_W'(i) == kept))) begin
        store_next[i] = gt_prev[i] ? prev[i] : vin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && sample_ok) begin
      for (int i = 0; i < MAX_SAMPLES; i++) begin
        store[i] <= store_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.pick) begin
      attempts <= '0;
      kept     <= '0;
    end else if (cmd.take) begin
      attempts <= attempts + CNT_W'(1);
      if (sample_ok && !full) begin
        kept <= kept + CNT_W'(1);
      end
    end
  end

  assign mid    = kept >> 1;
  assign median = store[mid[IDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pick) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      out_empty <= (kept == '0);
      out_value <= (kept == '0) ? '0 : median;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = amos_pkg::TDATA_W'(out_value) & amos_pkg::FIELD_MASK;
  assign m_tuser  = out_empty;

  `AMOS_ASSERT_ALWAYS(a_kept_bounded, clk, rst, kept <= attempts)
  `AMOS_ASSERT_NEXT(a_pick_clears_run, clk, rst, cmd.pick, (kept == '0) && (attempts == '0))
  `AMOS_ASSERT_NEXT(a_pick_fills_output, clk, rst, cmd.pick, out_valid)
endmodule
`default_nettype wire

[rtl/adc_median_of_samples.sv]
// After a run's last attempt word is accepted, the controller moves to its pick state, which
// loads the median into the output register, raising m_tvalid. Throughput: one attempt word
// per cycle, but not during a pick, which lowers s_tready and waits out an unaccepted median.
// A finished median waits in its own register, so the next run's words keep flowing.
// Reset (synchronous, rst high) clears the run counters and output valid; sample_count
// returns to 1. Store entries are not cleared and are read only once written.
`default_nettype none
module adc_median_of_samples #(
  parameter int MAX_SAMPLES = amos_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = amos_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [amos_pkg::TDATA_W-1:0]     s_tdata,   // [11:0] sample_value
  input  wire logic                             s_tuser,   // [0] sample_ok
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [amos_pkg::TDATA_W-1:0]          m_tdata,   // [11:0] median_value
  output logic                                  m_tuser,   // [0] no_samples
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [amos_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [amos_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [amos_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);
  logic [amos_pkg::CFG_W-1:0] sample_count;
  logic                       reg_hit;
  amos_pkg::dp_cmd_t          cmd;
  amos_pkg::dp_stat_t         stat;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[amos_pkg::APB_ADDR_W-1:2] == amos_pkg::REG_SAMPLE_COUNT);
  assign prdata  = reg_hit ? amos_pkg::APB_DATA_W'(sample_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= amos_pkg::CFG_W'(1);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      sample_count <= pwdata[amos_pkg::CFG_W-1:0];
    end
  end

  amos_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  amos_dp #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .sample_count (sample_count),
    .sample_value (s_tdata[amos_pkg::FIELD_W-1:0]),
    .sample_ok    (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser)
  );
endmodule
`default_nettype wire

[sim/tb_adc_median_of_samples.sv]
// Self-checking testbench for the median filter: stream driver, APB writes, predictor and monitor.
module tb_adc_median_of_samples;
  localparam int FIELD_W     = amos_pkg::FIELD_W;
  localparam int TDATA_W     = amos_pkg::TDATA_W;
  localparam int CFG_W       = amos_pkg::CFG_W;
  localparam int APB_ADDR_W  = amos_pkg::APB_ADDR_W;
  localparam int APB_DATA_W  = amos_pkg::APB_DATA_W;
  localparam logic [APB_ADDR_W-3:0] REG_SAMPLE_COUNT = amos_pkg::REG_SAMPLE_COUNT;

  localparam int NMAX        = amos_pkg::MAX_SAMPLES_DEF;
  localparam int IDLE_PCT    = 26;
  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_ITEMS = 700;

  typedef struct packed {
    logic [FIELD_W-1:0] value;
    logic               ok;
  } attempt_t;

  typedef struct packed {
    logic [FIELD_W-1:0] median;
    logic               empty;
  } median_t;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [TDATA_W-1:0]    s_tdata  = '0;
  logic                  s_tuser  = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [TDATA_W-1:0]    m_tdata;
  logic                  m_tuser;
  logic                  psel     = 1'b0;
  logic                  penable  = 1'b0;
  logic                  pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0] paddr    = '0;
  logic [APB_DATA_W-1:0] pwdata   = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  attempt_t           attempts_queued[$];
  median_t            medians_due[$];
  logic [FIELD_W-1:0] sorted_kept[NMAX];
  int                 kept_n    = 0;
  int                 seen_n    = 0;
  logic [CFG_W-1:0]   count_reg = CFG_W'(1);
  int                 errors    = 0;
  int                 sent      = 0;
  int                 quiet     = 0;
  logic               calm      = 1'b0;

  adc_median_of_samples DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  function automatic int run_length(input logic [CFG_W-1:0] c);
    if (c == 0) return 1;
    if (int'(c) > NMAX) return NMAX;
    return int'(c);
  endfunction

  // Insertion into the sorted row, then the median once the run is complete.
  function void take_attempt(input logic [FIELD_W-1:0] v, input logic ok);
    int pos;
    if (ok && kept_n < NMAX) begin
      pos = kept_n;
      while (pos > 0 && sorted_kept[pos-1] > v) begin
        sorted_kept[pos] = sorted_kept[pos-1];
        pos--;
      end
      sorted_kept[pos] = v;
      kept_n++;
    end
    seen_n++;
    if (seen_n >= run_length(count_reg)) begin
      if (kept_n == 0) medians_due.push_back('{median: '0, empty: 1'b1});
      else medians_due.push_back('{median: sorted_kept[kept_n/2], empty: 1'b0});
      seen_n = 0;
      kept_n = 0;
    end
  endfunction

  always @(posedge clk) begin : drive_words
    attempt_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (attempts_queued.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        w = attempts_queued.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_W'(w.value);
        s_tuser  <= w.ok;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else     m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin : track_and_check
    median_t got;
    median_t want;
    if (!rst) begin
      if (psel && penable && pwrite && pready && paddr[APB_ADDR_W-1:2] == REG_SAMPLE_COUNT)
        count_reg = pwdata[CFG_W-1:0];
      if (psel && penable && !pwrite && pready && prdata !== APB_DATA_W'(count_reg)) begin
        $error("sample_count: expected %0d, got %0d", count_reg, prdata);
        errors++;
      end
      if (s_tvalid && s_tready) take_attempt(s_tdata[FIELD_W-1:0], s_tuser);
      if (m_tvalid && m_tready) begin
        got = '{median: m_tdata[FIELD_W-1:0], empty: m_tuser};
        if (medians_due.size() == 0) begin
          $error("median word with none expected: median_value %0d, no_samples %0d",
                 got.median, got.empty);
          errors++;
        end else begin
          want = medians_due.pop_front();
          if (got.median !== want.median) begin
            $error("median_value: expected %0d, got %0d", want.median, got.median);
            errors++;
          end
          if (got.empty !== want.empty) begin
            $error("no_samples: expected %0d, got %0d", want.empty, got.empty);
            errors++;
          end
        end
      end
    end
  end

  // Ends the run if the block stops moving words altogether.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic void queue_attempt(input logic [FIELD_W-1:0] v, input logic ok);
    attempts_queued.push_back('{value: v, ok: ok});
    sent++;
  endfunction

  function automatic logic [FIELD_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2, 3:    return FIELD_W'(16 * $urandom_range(3));  // repeats give ties in the sort
      default: return FIELD_W'($urandom());
    endcase
  endfunction

  // Waits until every word has gone in and every median has come out, plus the pipeline tail.
  task automatic drain();
    do @(negedge clk);
    while (attempts_queued.size() != 0 || s_tvalid || medians_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // Writes the count register and reads it straight back.
  task automatic write_count(input logic [CFG_W-1:0] c);
    logic [APB_DATA_W-1:0] junk;
    junk = APB_DATA_W'($urandom());
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SAMPLE_COUNT, 2'b00};
    pwdata  <= {junk[APB_DATA_W-1:CFG_W], c};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] cur;
    int runs;
    int len;
    int okpct;
    int phase;
    bit rewrite;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Count after reset is one: every word is a run of its own.
    queue_attempt('0, 1'b1);
    queue_attempt('1, 1'b1);
    queue_attempt(FIELD_W'('h5a5), 1'b0);
    queue_attempt(FIELD_W'('ha5a), 1'b1);
    drain();
    // A count of zero behaves as one.
    write_count('0);
    queue_attempt('1, 1'b1);
    queue_attempt('0, 1'b0);
    drain();
    // Even run length picks the upper median.
    write_count(CFG_W'(4));
    queue_attempt('1, 1'b1);
    queue_attempt('0, 1'b1);
    queue_attempt(FIELD_W'(7), 1'b1);
    queue_attempt(FIELD_W'(3), 1'b1);
    drain();
    // A failed read still counts as an attempt.
    write_count(CFG_W'(3));
    queue_attempt(FIELD_W'(100), 1'b1);
    queue_attempt('1, 1'b0);
    queue_attempt(FIELD_W'(50), 1'b1);
    drain();
    // Every read fails: empty run.
    write_count(CFG_W'(2));
    queue_attempt('1, 1'b0);
    queue_attempt('0, 1'b0);
    drain();
    // Count lowered below the attempts already taken: the next word ends the run.
    write_count(CFG_W'(5));
    queue_attempt(FIELD_W'(9), 1'b1);
    queue_attempt(FIELD_W'(4), 1'b1);
    queue_attempt(FIELD_W'(6), 1'b1);
    drain();
    write_count(CFG_W'(2));
    queue_attempt(FIELD_W'(1), 1'b1);
    drain();

    cur = CFG_W'(2);
    sent = 0;
    phase = 0;
    rewrite = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      phase++;
      if (rewrite) begin
        case ($urandom_range(9))
          0:       cur = '0;
          1, 2:    cur = '1;
          3:       cur = CFG_W'(1);
          default: cur = CFG_W'($urandom_range(15));
        endcase
        write_count(cur);
      end
      calm = (phase % 7 == 3);
      runs = $urandom_range(1, 6);
      len  = run_length(cur);
      for (int r = 0; r < runs; r++) begin
        okpct = ($urandom_range(3) == 0) ? $urandom_range(100) : 85;
        for (int k = 0; k < len; k++)
          queue_attempt(pick_value(), $urandom_range(99) < okpct);
      end
      // Sometimes leave a run half done, so the next count lands mid-run.
      if (len > 1 && $urandom_range(3) == 0) begin
        for (int k = $urandom_range(1, len - 1); k > 0; k--)
          queue_attempt(pick_value(), $urandom_range(99) < 85);
      end
      rewrite = ($urandom_range(2) != 0);
      if (rewrite || $urandom_range(3) == 0) drain();
    end

    calm = 1'b0;
    drain();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
